### hdl/pdgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdgn_pkg
// shared widths, lane type and divider step for the grid normalizer
// ----------------------------------------------------------------------------
package pdgn_pkg;

  localparam int CoordW = 32;
  localparam int SizeW  = 14;
  localparam int GridW  = 16;
  localparam int ZW     = 31;               // clamped depth is positive
  localparam int DenW   = ZW + SizeW;       // depth times size
  localparam int QuoW   = 15;               // quotient bits, up to 2^15 - 1
  localparam int RemW   = DenW + QuoW - 1;  // room for den << 14
  localparam int NumW   = RemW + 1;         // signed numerator
  localparam int DivStages = QuoW;
  localparam logic [GridW-1:0] GridLimit = GridW'(16384);

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  // one restoring division step for quotient bit bit_idx
  function automatic lane_t div_step(lane_t l, int bit_idx);
    lane_t           r;
    logic [RemW-1:0] shd;
    begin
      r   = l;
      shd = RemW'(l.den) << bit_idx;
      if (l.rem >= shd) begin
        r.rem          = l.rem - shd;
        r.quo[bit_idx] = 1'b1;
      end
      return r;
    end
  endfunction

endpackage

### hdl/pdgn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdgn channel interfaces
// point request in, grid result out, valid/ready handshake
// ----------------------------------------------------------------------------
interface pdgn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        [13:0] image_width;
  logic        [13:0] image_height;
  modport source(output valid, point_x, point_y, point_z, image_width, image_height,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, image_width, image_height,
               output ready);
endinterface

interface pdgn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] grid_x;
  logic signed [15:0] grid_y;
  modport source(output valid, grid_x, grid_y, input ready);
  modport sink(input valid, grid_x, grid_y, output ready);
endinterface

### hdl/perspective_divide_grid_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_divide_grid_normalize
// perspective divide and grid-sample normalization, fully pipelined
// ----------------------------------------------------------------------------
// Takes one point request per cycle unless held and returns grid =
// 2*coord/(z*size) - 1 for x (with width) and y (with height) in signed
// Q3.13, truncated toward zero and saturated to [-2, 2]. Depth below one LSB
// is clamped to one LSB, a size of zero counts as one pixel. Stage a holds
// the depth-times-size multiply, stage b numerator and saturation detect,
// then 15 restoring divider stages (one quotient bit each), one output register.
// Throughput is one request per cycle; the whole pipe holds while the
// output result waits and a bubble exists nowhere to absorb it, so ready
// follows the output side.
module perspective_divide_grid_normalize
  import pdgn_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pdgn_in_if.sink       in_i,
  pdgn_out_if.source    out_o
);

  localparam int NV = DivStages + 3;

  logic          adv;
  logic [NV-1:0] v_q;

  // stage a: clamped depth times size
  logic signed [CoordW-1:0] a_x_q, a_y_q;
  logic [DenW-1:0]          a_dx_q, a_dy_q;
  logic [ZW-1:0]            zc;
  logic [SizeW-1:0]         wc, hc;

  // divider lanes, index 0 is stage b output
  lane_t lx_q [DivStages+1];
  lane_t ly_q [DivStages+1];

  logic signed [GridW-1:0] gx_q, gy_q;

  assign adv        = out_o.ready || !v_q[NV-1];
  assign in_i.ready = adv;

  always_comb begin
    zc = (in_i.point_z < 32'sd1) ? ZW'(1) : in_i.point_z[ZW-1:0];
    wc = (in_i.image_width  == '0) ? SizeW'(1) : in_i.image_width;
    hc = (in_i.image_height == '0) ? SizeW'(1) : in_i.image_height;
  end

  // numerator and overflow detect for one lane
  function automatic lane_t lane_init(logic signed [CoordW-1:0] c, logic [DenW-1:0] d);
    lane_t                  l;
    logic signed [NumW-1:0] num;
    logic        [NumW-1:0] mag;
    logic        [NumW-1:0] lim;
    begin
      num   = ($signed({{(NumW-CoordW-14){c[CoordW-1]}}, c, 14'b0}))
            - $signed({{(NumW-DenW-13){1'b0}}, d, 13'b0});
      l.neg = num[NumW-1];
      mag   = l.neg ? NumW'(-num) : NumW'(num);
      lim   = {{(NumW-DenW-14){1'b0}}, d, 14'b0} + NumW'(d);  // 16385 * den
      l.ovf = mag >= lim;
      l.den = d;
      l.rem = mag[RemW-1:0];
      l.quo = '0;
      return l;
    end
  endfunction

  // final sign and saturation
  function automatic logic signed [GridW-1:0] lane_out(lane_t l);
    logic [GridW-1:0] mag;
    begin
      mag = l.ovf ? GridLimit : GridW'(l.quo);
      return l.neg ? $signed(-mag) : $signed(mag);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NV-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q  <= in_i.point_x;
      a_y_q  <= in_i.point_y;
      a_dx_q <= DenW'(zc) * DenW'(wc);
      a_dy_q <= DenW'(zc) * DenW'(hc);
      lx_q[0] <= lane_init(a_x_q, a_dx_q);
      ly_q[0] <= lane_init(a_y_q, a_dy_q);
      // one quotient bit per stage, msb first
      for (int k = 0; k < DivStages; k++) begin
        lx_q[k+1] <= div_step(lx_q[k], QuoW - 1 - k);
        ly_q[k+1] <= div_step(ly_q[k], QuoW - 1 - k);
      end
      gx_q   <= lane_out(lx_q[DivStages]);
      gy_q   <= lane_out(ly_q[DivStages]);
    end
  end

  assign out_o.valid  = v_q[NV-1];
  assign out_o.grid_x = gx_q;
  assign out_o.grid_y = gy_q;

`ifndef NO_ASSERTIONS
  // results stay within the saturation range
  a_range_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.grid_x <= 16'sd16384 && out_o.grid_x >= -16'sd16384))
    else $error("grid_x out of range");
  a_range_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.grid_y <= 16'sd16384 && out_o.grid_y >= -16'sd16384))
    else $error("grid_y out of range");
  // a held pipe keeps its valid pattern
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipe moved while stalled");
`endif

endmodule
